// File: design/via_pkg.sv
package via_pkg;

  // request kinds
  localparam logic [2:0] REQ_READ   = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_T1_EXP = 3'd2;
  localparam logic [2:0] REQ_VBLANK = 3'd3;
  localparam logic [2:0] REQ_SECOND = 3'd4;

  // register index: address bits 12..9, low bits must be zero
  localparam logic [3:0] RS_ORB  = 4'd0;
  localparam logic [3:0] RS_DDRB = 4'd2;
  localparam logic [3:0] RS_DDRA = 4'd3;
  localparam logic [3:0] RS_T1CL = 4'd4;
  localparam logic [3:0] RS_T1CH = 4'd5;
  localparam logic [3:0] RS_T1LL = 4'd6;
  localparam logic [3:0] RS_T1LH = 4'd7;
  localparam logic [3:0] RS_T2CL = 4'd8;
  localparam logic [3:0] RS_T2CH = 4'd9;
  localparam logic [3:0] RS_SR   = 4'd10;
  localparam logic [3:0] RS_ACR  = 4'd11;
  localparam logic [3:0] RS_PCR  = 4'd12;
  localparam logic [3:0] RS_IFR  = 4'd13;
  localparam logic [3:0] RS_IER  = 4'd14;
  localparam logic [3:0] RS_ORA  = 4'd15;

  localparam logic [6:0] FLAG_T1  = 7'h40;
  localparam logic [6:0] FLAG_VBL = 7'h02;
  localparam logic [6:0] FLAG_SEC = 7'h01;
  localparam logic [1:0] T1_MODE_CONT = 2'b01;

  typedef struct packed {
    logic        take;
    logic [2:0]  kind;
    logic        reg_hit;
    logic [3:0]  reg_sel;
    logic [7:0]  data;
  } req_t;

  function automatic logic [6:0] set_or_clear(input logic [6:0] cur, input logic [7:0] v);
    logic [6:0] r;
    begin
      if (v[7]) begin
        r = cur | v[6:0];
      end else begin
        r = cur & ~v[6:0];
      end
      return r;
    end
  endfunction

endpackage

// File: design/via_core.sv
module via_core (
  input  logic          clk,
  input  logic          rst,
  input  via_pkg::req_t req,
  output logic [7:0]    rd_data,
  output logic          irq_next
);

  logic [7:0]  ora, orb, ddra, ddrb, pcr, acr, sr;
  logic [6:0]  ifr, ier;
  logic [15:0] t1c, t1l, t2c;

  logic [7:0]  ora_next, orb_next, ddra_next, ddrb_next, pcr_next, acr_next, sr_next;
  logic [6:0]  ifr_next, ier_next;
  logic [15:0] t1c_next, t1l_next, t2c_next;
  logic        reload_chk;

  // read mux
  always_comb begin
    rd_data = 8'h00;
    if (req.kind == via_pkg::REQ_READ && req.reg_hit) begin
      case (req.reg_sel)
        via_pkg::RS_ORA:  rd_data = ora;
        via_pkg::RS_ORB:  rd_data = orb;
        via_pkg::RS_DDRA: rd_data = ddra;
        via_pkg::RS_DDRB: rd_data = ddrb;
        via_pkg::RS_T1CL: rd_data = t1c[7:0];
        via_pkg::RS_T1CH: rd_data = t1c[15:8];
        via_pkg::RS_T1LL: rd_data = t1l[7:0];
        via_pkg::RS_T1LH: rd_data = t1l[15:8];
        via_pkg::RS_T2CL: rd_data = t2c[7:0];
        via_pkg::RS_T2CH: rd_data = t2c[15:8];
        via_pkg::RS_SR:   rd_data = sr;
        via_pkg::RS_ACR:  rd_data = acr;
        via_pkg::RS_PCR:  rd_data = pcr;
        via_pkg::RS_IFR:  rd_data = {(ifr != 7'h00), ifr};
        via_pkg::RS_IER:  rd_data = {1'b1, ier};
        default:          rd_data = 8'h00;
      endcase
    end
  end

  always_comb begin
    ora_next  = ora;
    orb_next  = orb;
    ddra_next = ddra;
    ddrb_next = ddrb;
    pcr_next  = pcr;
    acr_next  = acr;
    sr_next   = sr;
    ifr_next  = ifr;
    ier_next  = ier;
    t1c_next  = t1c;
    t1l_next  = t1l;
    t2c_next  = t2c;
    reload_chk = 1'b0;
    case (req.kind)
      via_pkg::REQ_WRITE: begin
        if (req.reg_hit) begin
          case (req.reg_sel)
            via_pkg::RS_ORA:  ora_next = (ora & ~ddra) | (req.data & ddra);
            via_pkg::RS_ORB:  orb_next = (orb & ~ddrb) | (req.data & ddrb);
            via_pkg::RS_DDRA: ddra_next = req.data;
            via_pkg::RS_DDRB: ddrb_next = req.data;
            via_pkg::RS_T1CL: t1c_next[7:0] = req.data;
            via_pkg::RS_T1CH: t1c_next[15:8] = req.data;
            via_pkg::RS_T1LL: t1l_next[7:0] = req.data;
            via_pkg::RS_T1LH: t1l_next[15:8] = req.data;
            via_pkg::RS_T2CL: t2c_next[7:0] = req.data;
            via_pkg::RS_T2CH: t2c_next[15:8] = req.data;
            via_pkg::RS_SR:   sr_next = req.data;
            via_pkg::RS_PCR:  pcr_next = req.data;
            via_pkg::RS_ACR: begin
              acr_next   = req.data;
              reload_chk = 1'b1;
            end
            via_pkg::RS_IFR: begin
              ifr_next   = via_pkg::set_or_clear(ifr, req.data);
              reload_chk = 1'b1;
            end
            via_pkg::RS_IER: begin
              ier_next   = via_pkg::set_or_clear(ier, req.data);
              reload_chk = 1'b1;
            end
            default: ;
          endcase
        end
      end
      via_pkg::REQ_T1_EXP: begin
        ifr_next   = ifr | via_pkg::FLAG_T1;
        reload_chk = 1'b1;
      end
      via_pkg::REQ_VBLANK: ifr_next = ifr | via_pkg::FLAG_VBL;
      via_pkg::REQ_SECOND: ifr_next = ifr | via_pkg::FLAG_SEC;
      default: ;
    endcase
    // reload sees the enables and ACR as left by this transfer
    if (reload_chk && (ier_next[6] || acr_next[7:6] == via_pkg::T1_MODE_CONT)) begin
      t1c_next = t1l_next;
    end
  end

  assign irq_next = (ifr_next & ier_next) != 7'h00;

  always_ff @(posedge clk) begin
    if (rst) begin
      ora  <= 8'h00;
      orb  <= 8'h00;
      ddra <= 8'h00;
      ddrb <= 8'h00;
      pcr  <= 8'h00;
      acr  <= 8'h00;
      sr   <= 8'h00;
      ifr  <= 7'h00;
      ier  <= 7'h00;
      t1c  <= 16'h0000;
      t1l  <= 16'h0000;
      t2c  <= 16'h0000;
    end else if (req.take) begin
      ora  <= ora_next;
      orb  <= orb_next;
      ddra <= ddra_next;
      ddrb <= ddrb_next;
      pcr  <= pcr_next;
      acr  <= acr_next;
      sr   <= sr_next;
      ifr  <= ifr_next;
      ier  <= ier_next;
      t1c  <= t1c_next;
      t1l  <= t1l_next;
      t2c  <= t2c_next;
    end
  end

endmodule

// File: design/versatile_interface_adapter_regs.sv
// channel  | valid     | stall     | payload
// request  | in_valid  | in_stall  | req_type, address, write_data
// result   | out_valid | out_stall | read_data, irq_line
//
// One transfer per cycle while in_stall is low; the result appears in the cycle after the request is taken.
// Register update and read mux are one level of logic into the result register.
// Synchronous reset clears the register file and the result valid.
// in_stall is raised only while a held result is itself stalled.
module versatile_interface_adapter_regs (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [12:0] address,
  input  logic [7:0]  write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_data,
  output logic        irq_line
);

  via_pkg::req_t req;
  logic [7:0]    rd_data;
  logic          irq_next;

  assign in_stall = out_valid && out_stall;

  always_comb begin
    req.take    = in_valid && !in_stall;
    req.kind    = req_type;
    req.reg_hit = (address[8:0] == 9'h000);
    req.reg_sel = address[12:9];
    req.data    = write_data;
  end

  via_core u_core (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rd_data  (rd_data),
    .irq_next (irq_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req.take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.take) begin
      read_data <= rd_data;
      irq_line  <= irq_next;
    end
  end

endmodule
